/* hdl/slpsg_pkg.sv */
`default_nettype none

package slpsg_pkg;

  // Sample grid and field widths
  localparam int unsigned GridSide = 128;
  localparam int unsigned IdxW     = 14;
  localparam int unsigned ColW     = $clog2(GridSide);
  localparam int unsigned RowW     = IdxW - ColW;
  localparam int unsigned JitW     = 16;
  localparam int unsigned CoordW   = 23;
  localparam int unsigned WordW    = 32;
  localparam int unsigned CfgIdxW  = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCRAMBLE_A = 2'd0,
    CFG_SCRAMBLE_B = 2'd1,
    CFG_SCRAMBLE_C = 2'd2
  } cfg_idx_e;

  // Payload of one request on the point channel
  typedef struct packed {
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [WordW-1:0]  coord_z;
  } point_t;

  typedef logic [WordW-1:0][WordW-1:0] zcols_t;

  // Columns of the z generator matrix; column k is bits 62..31 of step k
  function automatic zcols_t z_cols_f();
    logic [63:0] c;
    zcols_t      r;
    c = 64'(3) << 62;
    for (int k = 0; k < 32; k++) begin
      r[k] = c[62:31];
      c    = c ^ (c >> 1);
    end
    return r;
  endfunction

  localparam zcols_t ZCols = z_cols_f();

  // LP radical inverse: bit k sets the top k+1 bits, so out bit j is the
  // parity of input bits 31-j and up
  function automatic logic [WordW-1:0] lp_radical(input logic [WordW-1:0] n);
    logic [WordW-1:0] r;
    for (int j = 0; j < 32; j++) begin
      r[j] = ^(n >> (31 - j));
    end
    return r;
  endfunction

  // Inverse matrix: bit k sets bits 31-k and 30-k
  function automatic logic [WordW-1:0] lp_solve(input logic [WordW-1:0] n);
    logic [WordW-1:0] r;
    r[31] = n[0];
    for (int j = 0; j < 31; j++) begin
      r[j] = n[31-j] ^ n[30-j];
    end
    return r;
  endfunction

  // Third coordinate: XOR of the selected constant columns over a seed
  function automatic logic [WordW-1:0] z_matrix(input logic [WordW-1:0] n,
                                                 input logic [WordW-1:0] seed);
    logic [WordW-1:0] acc;
    acc = seed;
    for (int k = 0; k < 32; k++) begin
      if (n[k]) begin
        acc = acc ^ ZCols[k];
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

/* hdl/slpsg_if.sv */
`default_nettype none

// Sample index request channel
interface slpsg_idx_if import slpsg_pkg::*;;
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink   (input valid, input sample_index, output ready);
endinterface

// Point result channel
interface slpsg_pt_if import slpsg_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] coord_x;
  logic [CoordW-1:0] coord_y;
  logic [WordW-1:0]  coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  output ready);
endinterface

`default_nettype wire

/* hdl/scrambled_lp_sample_generator_top.sv */
// Scrambled stratified 3D sample generator.
// idx_chan (sink): one request carries a 14-bit sample_index; column = low
//   bits, row = high bits of the 128 x 128 grid.
// pt_chan (source): one request per index with coord_x and coord_y (23-bit
//   fractions, cell*65536 + jitter) and coord_z (32-bit fraction).
// Config port: cfg_we_i writes cfg_data_i to scramble_a/b/c (index 0/1/2);
//   index 3 is ignored. Write only while no request is in flight.
// An accepted index passes the input register, then the result register.
//   Throughput: one point per cycle while pt_chan.ready is high; the XOR
//   networks between the two registers are the only work per item.
// Stall: when pt_chan.ready is low the result holds, the input register
//   keeps its index, and idx_chan.ready drops once both stages are full;
//   no request is lost or repeated.
// Reset: rst_ni clears both valid flags and the scramble words to zero.
`default_nettype none

module scrambled_lp_sample_generator_top import slpsg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [WordW-1:0]   cfg_data_i,
  slpsg_idx_if.sink               idx_chan,
  slpsg_pt_if.source              pt_chan
);

  logic [WordW-1:0] scr_a_q, scr_b_q, scr_c_q;
  logic             s1_vld_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic             out_vld_q;
  point_t           out_pt_q;
  point_t           pt_d;
  logic             out_adv;
  logic             s1_adv;
  logic             in_acc;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_a_q <= '0;
      scr_b_q <= '0;
      scr_c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SCRAMBLE_A: scr_a_q <= cfg_data_i;
        CFG_SCRAMBLE_B: scr_b_q <= cfg_data_i;
        CFG_SCRAMBLE_C: scr_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: result slot frees when empty or taken
  assign out_adv        = !out_vld_q || pt_chan.ready;
  assign s1_adv         = s1_vld_q && out_adv;
  assign idx_chan.ready = !s1_vld_q || out_adv;
  assign in_acc         = idx_chan.valid && idx_chan.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (idx_chan.ready) begin
      s1_vld_q <= idx_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q <= idx_chan.sample_index;
    end
  end

  // Point computation
  always_comb begin
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic [WordW-1:0] hi, lp_hi, delta, seq, xs, ys;
    col   = s1_idx_q[ColW-1:0];
    row   = s1_idx_q[IdxW-1:ColW];
    hi    = {JitW'(col) ^ scr_a_q[WordW-1:JitW], {JitW{1'b0}}};
    lp_hi = lp_radical(hi) ^ scr_b_q;
    delta = (WordW'(row) << JitW) ^ {lp_hi[WordW-1:JitW], {JitW{1'b0}}};
    seq   = hi | lp_solve(delta);
    xs    = seq ^ scr_a_q;
    ys    = lp_hi ^ delta;
    pt_d.coord_x = CoordW'({col, xs[JitW-1:0]});
    pt_d.coord_y = CoordW'({row, ys[JitW-1:0]});
    pt_d.coord_z = z_matrix(seq, scr_c_q);
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pt_q <= pt_d;
    end
  end

  assign pt_chan.valid   = out_vld_q;
  assign pt_chan.coord_x = out_pt_q.coord_x;
  assign pt_chan.coord_y = out_pt_q.coord_y;
  assign pt_chan.coord_z = out_pt_q.coord_z;

`ifndef SYNTHESIS
  // A new result only appears from a filled input stage
  a_out_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q ##1 out_vld_q |-> $past(s1_vld_q))
    else $error("result valid without a staged index");

  // Input stalls only when both stages are full and the sink holds off
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idx_chan.ready |-> (s1_vld_q && out_vld_q && !pt_chan.ready))
    else $error("input stalled without back-pressure");

  // A held index in the input stage keeps its value
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !out_adv) |=> (s1_vld_q && $stable(s1_idx_q)))
    else $error("staged index lost during stall");
`endif

endmodule

`default_nettype wire

/* test/tb_scrambled_lp_sample_generator_top.sv */
`default_nettype none

module tb_scrambled_lp_sample_generator_top import slpsg_pkg::*;;

  localparam int StallLimit = 2000;  // cycles with no request moving on either side
  localparam int HoldCycles = 300;   // long receiver hold-off for the fill-up test

  typedef struct {
    logic [IdxW-1:0] idx;
    point_t          pt;
  } pending_point_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [WordW-1:0]    cfg_data_i;

  slpsg_idx_if idx_bus ();
  slpsg_pt_if  pt_bus ();

  // Mirror of the scramble words
  logic [WordW-1:0]    scr_a;
  logic [WordW-1:0]    scr_b;
  logic [WordW-1:0]    scr_c;

  pending_point_t      expected_points[$];
  int                  mismatches   = 0;
  int                  src_idle_pct = 0;
  int                  sink_idle_pct = 0;
  int unsigned         hold_order   = 0;
  int                  quiet_cycles = 0;

  scrambled_lp_sample_generator_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .idx_chan   (idx_bus),
    .pt_chan    (pt_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Point predictor
  // ---------------------------------------------------------------------------

  // Radical inverse: index bit k flips the top k+1 bits
  function automatic logic [WordW-1:0] radical_fold(input logic [WordW-1:0] n);
    logic [WordW-1:0] acc;
    logic [WordW-1:0] mask;
    acc  = '0;
    mask = 32'h8000_0000;
    for (int k = 0; k < WordW; k++) begin
      if (n[k]) acc ^= mask;
      mask |= mask >> 1;
    end
    return acc;
  endfunction

  // Inverse matrix: bit k flips a two-bit pair sliding down from the top
  function automatic logic [WordW-1:0] cell_solve(input logic [WordW-1:0] n);
    logic [WordW-1:0] acc;
    logic [WordW-1:0] mask;
    acc  = '0;
    mask = 32'hC000_0000;
    for (int k = 0; k < WordW; k++) begin
      if (n[k]) acc ^= mask;
      mask >>= 1;
    end
    return acc;
  endfunction

  // Third coordinate: columns are a 32-bit window of a shifting XOR step
  function automatic logic [WordW-1:0] z_fold(input logic [WordW-1:0] n,
                                              input logic [WordW-1:0] seed);
    logic [WordW-1:0] acc;
    logic [63:0]      step;
    acc  = seed;
    step = 64'h3 << 62;
    for (int k = 0; k < WordW; k++) begin
      if (n[k]) acc ^= step[62:31];
      step ^= step >> 1;
    end
    return acc;
  endfunction

  function automatic point_t predict_point(input logic [IdxW-1:0] idx);
    logic [ColW-1:0]  cell_col;
    logic [RowW-1:0]  cell_row;
    logic [WordW-1:0] hi;
    logic [WordW-1:0] lp_hi;
    logic [WordW-1:0] delta;
    logic [WordW-1:0] seq;
    logic [WordW-1:0] xs;
    logic [WordW-1:0] ys;
    point_t           p;
    cell_col = idx[ColW-1:0];
    cell_row = idx[IdxW-1:ColW];
    hi       = {16'(cell_col) ^ scr_a[31:16], 16'h0000};
    lp_hi    = radical_fold(hi) ^ scr_b;
    delta    = {16'(cell_row) ^ lp_hi[31:16], 16'h0000};
    seq      = hi | cell_solve(delta);
    xs       = seq ^ scr_a;
    ys       = lp_hi ^ delta;
    p.coord_x = {cell_col, xs[15:0]};
    p.coord_y = {cell_row, ys[15:0]};
    p.coord_z = z_fold(seq, scr_c);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [IdxW-1:0] idx,
                                 input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    $display("mismatch %s (index %0d): got %h want %h", what, idx, got, want);
    mismatches++;
  endtask

  // Compare each point request with the oldest prediction
  always @(posedge clk_i) begin
    pending_point_t head;
    if (rst_ni && pt_bus.valid && pt_bus.ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point", '0, 32'(pt_bus.coord_x), 32'(pt_bus.coord_y));
      end else begin
        head = expected_points.pop_front();
        if (pt_bus.coord_x !== head.pt.coord_x)
          report_mismatch("coord_x", head.idx, 32'(pt_bus.coord_x), 32'(head.pt.coord_x));
        if (pt_bus.coord_y !== head.pt.coord_y)
          report_mismatch("coord_y", head.idx, 32'(pt_bus.coord_y), 32'(head.pt.coord_y));
        if (pt_bus.coord_z !== head.pt.coord_z)
          report_mismatch("coord_z", head.idx, pt_bus.coord_z, head.pt.coord_z);
      end
    end
  end

  // Watchdog: ends the run when no request moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (idx_bus.valid && idx_bus.ready) || (pt_bus.valid && pt_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is ordered
  initial begin
    int unsigned hold_seen;
    int          hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    pt_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_order != hold_seen) begin
        hold_seen = hold_order;
        hold_left = HoldCycles;
      end
      if (!rst_ni || hold_left > 0) begin
        pt_bus.ready <= 1'b0;
        if (hold_left > 0) hold_left--;
      end else begin
        pt_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender and configuration helpers
  // ---------------------------------------------------------------------------

  // Offer one index request; returns at the edge where it is taken
  task automatic send_index(input logic [IdxW-1:0] idx);
    pending_point_t entry;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      idx_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    idx_bus.valid        <= 1'b1;
    idx_bus.sample_index <= idx;
    @(posedge clk_i);
    while (!idx_bus.ready) @(posedge clk_i);
    entry.idx = idx;
    entry.pt  = predict_point(idx);
    expected_points.push_back(entry);
  endtask

  task automatic stop_sending();
    idx_bus.valid <= 1'b0;
  endtask

  // Wait for every predicted point, then let the pipeline settle
  task automatic drain_points();
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write all three scramble words on consecutive edges; block must be idle
  task automatic load_scrambles(input logic [WordW-1:0] a, input logic [WordW-1:0] b,
                                input logic [WordW-1:0] c);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SCRAMBLE_A;
    cfg_data_i <= a;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SCRAMBLE_B;
    cfg_data_i <= b;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SCRAMBLE_C;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    scr_a = a;
    scr_b = b;
    scr_c = c;
  endtask

  // Scramble word with a bias toward the extremes
  function automatic logic [WordW-1:0] pick_scramble();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Grid corners and every single index bit at reset scrambles
  task automatic test_reset_corners();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_index(IdxW'(0));
    send_index(IdxW'(16383));
    send_index(IdxW'(GridSide - 1));
    send_index(IdxW'(16383 - (GridSide - 1)));
    for (int b = 0; b < IdxW; b++) send_index(IdxW'(1) << b);
    stop_sending();
    drain_points();
  endtask

  // Corners under saturated and alternating scramble words
  task automatic test_scramble_extremes();
    load_scrambles('1, '1, '1);
    send_index(IdxW'(0));
    send_index(IdxW'(16383));
    send_index(IdxW'(GridSide - 1));
    send_index(IdxW'(16383 - (GridSide - 1)));
    stop_sending();
    drain_points();
    load_scrambles(32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0001);
    send_index(IdxW'(0));
    send_index(IdxW'(16383));
    stop_sending();
    drain_points();
  endtask

  // Random indexes, new scramble words per batch
  task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                     input int batches, input int per_batch);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int n = 0; n < batches; n++) begin
      load_scrambles(pick_scramble(), pick_scramble(), pick_scramble());
      repeat (per_batch) send_index(IdxW'($urandom));
      stop_sending();
      drain_points();
    end
  endtask

  // Receiver holds off while the sender keeps pushing; input must stall
  task automatic test_output_hold();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    load_scrambles($urandom, $urandom, $urandom);
    hold_order++;
    repeat (60) send_index(IdxW'($urandom));
    stop_sending();
    drain_points();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_SCRAMBLE_A;
    cfg_data_i           = '0;
    idx_bus.valid        = 1'b0;
    idx_bus.sample_index = '0;
    scr_a                = '0;
    scr_b                = '0;
    scr_c                = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_corners();
    test_scramble_extremes();
    test_random_traffic(13, 68, 3, 120);
    test_random_traffic(68, 13, 3, 120);
    test_random_traffic(0, 0, 3, 120);
    test_output_hold();

    drain_points();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
